/* src/cau_pkg.sv */
// Shared types and defaults of the complex arithmetic unit.
// Used by the channel interfaces, the top-level datapath module and the checker.
// Depends on nothing.
package cau_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_MAG = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

endpackage

/* src/cau_if.sv */
// Valid/ready channels of the complex arithmetic unit: operand beats in,
// result beats out. Depends on cau_pkg for the default data width.
interface cau_in_if #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic [2:0]                   opcode;
    logic signed [DATA_WIDTH-1:0] a_real;
    logic signed [DATA_WIDTH-1:0] a_imag;
    logic signed [DATA_WIDTH-1:0] b_real;
    logic signed [DATA_WIDTH-1:0] b_imag;

    modport source (output valid, opcode, a_real, a_imag, b_real, b_imag, input ready);
    modport sink   (input valid, opcode, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] result_real;
    logic signed [DATA_WIDTH-1:0] result_imag;
    logic [1:0]                   status;

    modport source (output valid, result_real, result_imag, status, input ready);
    modport sink   (input valid, result_real, result_imag, status, output ready);
endinterface

/* src/complex_arithmetic_unit.sv */
// Complex arithmetic unit: fully pipelined, takes one operand beat per cycle
// and returns one result beat for each. The depth comes from the divide /
// square root chain, which settles one quotient bit per stage and one root
// bit in each stage but the last; products take one stage, sums one, divider
// setup one, and the output register one. cmd.ready drops only while the output
// register holds a beat that res has not taken, and then the whole pipe holds.
// Depends on cau_pkg, cau_in_if / cau_out_if and cau_step.
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input logic       clk,
    input logic       rst_n,
    cau_in_if.sink    cmd,
    cau_out_if.source res
);
    localparam int W      = DATA_WIDTH;
    localparam int PW     = 2 * W;
    localparam int RW     = 3 * W + FRAC_BITS + 1;
    localparam int SQW    = 2 * W + 1;
    localparam int NSTEP  = W + 1;
    localparam int SIDE_W = 2 + 2 * W + 2 + 4;

    localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINNEG = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [1:0] {
        SEL_EARLY = 2'd0,
        SEL_DIV   = 2'd1,
        SEL_MAG   = 2'd2
    } sel_t;

    // {saturated, value}
    function automatic logic [W:0] sat_wide(input logic [SQW-1:0] v);
        logic hi;
        logic lo;
        begin
            hi = !v[SQW-1] && (|v[SQW-2:W-1]);
            lo =  v[SQW-1] && !(&v[SQW-2:W-1]);
            if (hi)
                sat_wide = {1'b1, MAXPOS};
            else if (lo)
                sat_wide = {1'b1, MINNEG};
            else
                sat_wide = {1'b0, v[W-1:0]};
        end
    endfunction

    logic res_valid_reg;
    logic en;
    assign en        = !res_valid_reg || res.ready;
    assign cmd.ready = en;

    // stage 1: products and plain sums
    logic                 s1_valid_reg;
    cau_pkg::op_t         s1_op_reg;
    logic signed [W:0]    s1_sum_re_reg;
    logic signed [W:0]    s1_sum_im_reg;
    logic signed [PW-1:0] s1_p_rr_reg;
    logic signed [PW-1:0] s1_p_ii_reg;
    logic signed [PW-1:0] s1_p_ri_reg;
    logic signed [PW-1:0] s1_p_ir_reg;
    logic signed [PW-1:0] s1_q_br_reg;
    logic signed [PW-1:0] s1_q_bi_reg;
    logic signed [PW-1:0] s1_q_ar_reg;
    logic signed [PW-1:0] s1_q_ai_reg;
    logic signed [W:0]    sum_re_next;
    logic signed [W:0]    sum_im_next;

    always_comb
    begin
        if (cau_pkg::op_t'(cmd.opcode) == cau_pkg::OP_SUB)
        begin
            sum_re_next = {cmd.a_real[W-1], cmd.a_real} - {cmd.b_real[W-1], cmd.b_real};
            sum_im_next = {cmd.a_imag[W-1], cmd.a_imag} - {cmd.b_imag[W-1], cmd.b_imag};
        end
        else
        begin
            sum_re_next = {cmd.a_real[W-1], cmd.a_real} + {cmd.b_real[W-1], cmd.b_real};
            sum_im_next = {cmd.a_imag[W-1], cmd.a_imag} + {cmd.b_imag[W-1], cmd.b_imag};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_op_reg     <= cau_pkg::op_t'(cmd.opcode);
            s1_sum_re_reg <= sum_re_next;
            s1_sum_im_reg <= sum_im_next;
            s1_p_rr_reg   <= cmd.a_real * cmd.b_real;
            s1_p_ii_reg   <= cmd.a_imag * cmd.b_imag;
            s1_p_ri_reg   <= cmd.a_real * cmd.b_imag;
            s1_p_ir_reg   <= cmd.a_imag * cmd.b_real;
            s1_q_br_reg   <= cmd.b_real * cmd.b_real;
            s1_q_bi_reg   <= cmd.b_imag * cmd.b_imag;
            s1_q_ar_reg   <= cmd.a_real * cmd.a_real;
            s1_q_ai_reg   <= cmd.a_imag * cmd.a_imag;
        end
    end

    // stage 2: cross sums, early results, divider operands
    logic signed [SQW-1:0] mul_re;
    logic signed [SQW-1:0] mul_im;
    logic signed [SQW-1:0] mul_re_sh;
    logic signed [SQW-1:0] mul_im_sh;
    logic signed [SQW-1:0] num_re;
    logic signed [SQW-1:0] num_im;
    logic [PW-1:0]         den_next;
    logic [W:0]            sat_re;
    logic [W:0]            sat_im;
    logic [W-1:0]          early_re_next;
    logic [W-1:0]          early_im_next;
    cau_pkg::status_t      early_st_next;
    sel_t                  sel_next;

    assign mul_re    = {s1_p_rr_reg[PW-1], s1_p_rr_reg} - {s1_p_ii_reg[PW-1], s1_p_ii_reg};
    assign mul_im    = {s1_p_ri_reg[PW-1], s1_p_ri_reg} + {s1_p_ir_reg[PW-1], s1_p_ir_reg};
    assign mul_re_sh = mul_re >>> FRAC_BITS;
    assign mul_im_sh = mul_im >>> FRAC_BITS;
    assign num_re    = {s1_p_rr_reg[PW-1], s1_p_rr_reg} + {s1_p_ii_reg[PW-1], s1_p_ii_reg};
    assign num_im    = {s1_p_ir_reg[PW-1], s1_p_ir_reg} - {s1_p_ri_reg[PW-1], s1_p_ri_reg};
    assign den_next  = s1_q_br_reg + s1_q_bi_reg;

    always_comb
    begin
        sat_re        = '0;
        sat_im        = '0;
        early_re_next = '0;
        early_im_next = '0;
        early_st_next = cau_pkg::ST_OK;
        sel_next      = SEL_EARLY;
        unique case (s1_op_reg)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB:
            begin
                sat_re = sat_wide({{(SQW-W-1){s1_sum_re_reg[W]}}, s1_sum_re_reg});
                sat_im = sat_wide({{(SQW-W-1){s1_sum_im_reg[W]}}, s1_sum_im_reg});
            end
            cau_pkg::OP_MUL:
            begin
                sat_re = sat_wide(mul_re_sh);
                sat_im = sat_wide(mul_im_sh);
            end
            cau_pkg::OP_DIV:
            begin
                if (den_next == '0)
                    early_st_next = cau_pkg::ST_DIVZ;
                else
                    sel_next = SEL_DIV;
            end
            cau_pkg::OP_MAG:
            begin
                sel_next = SEL_MAG;
            end
            default:
            begin
                sel_next = SEL_EARLY;
            end
        endcase
        if (s1_op_reg == cau_pkg::OP_ADD || s1_op_reg == cau_pkg::OP_SUB
            || s1_op_reg == cau_pkg::OP_MUL)
        begin
            early_re_next = sat_re[W-1:0];
            early_im_next = sat_im[W-1:0];
            if (sat_re[W] || sat_im[W])
                early_st_next = cau_pkg::ST_SAT;
        end
    end

    logic                 s2_valid_reg;
    sel_t                 s2_sel_reg;
    logic [W-1:0]         s2_early_re_reg;
    logic [W-1:0]         s2_early_im_reg;
    cau_pkg::status_t     s2_early_st_reg;
    logic                 s2_neg_r_reg;
    logic                 s2_neg_i_reg;
    logic [PW-1:0]        s2_mag_r_reg;
    logic [PW-1:0]        s2_mag_i_reg;
    logic [PW-1:0]        s2_den_reg;
    logic [PW-1:0]        s2_n_reg;
    logic [SQW-1:0]       abs_re;
    logic [SQW-1:0]       abs_im;

    assign abs_re = num_re[SQW-1] ? -num_re : num_re;
    assign abs_im = num_im[SQW-1] ? -num_im : num_im;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_sel_reg      <= sel_next;
            s2_early_re_reg <= early_re_next;
            s2_early_im_reg <= early_im_next;
            s2_early_st_reg <= early_st_next;
            s2_neg_r_reg    <= num_re[SQW-1];
            s2_neg_i_reg    <= num_im[SQW-1];
            s2_mag_r_reg    <= abs_re[PW-1:0];
            s2_mag_i_reg    <= abs_im[PW-1:0];
            s2_den_reg      <= den_next;
            s2_n_reg        <= s1_q_ar_reg + s1_q_ai_reg;
        end
    end

    // stage 3: divider setup; flag quotients that cannot fit W+1 bits
    logic [RW-1:0] rem_r_init;
    logic [RW-1:0] rem_i_init;
    logic [RW-1:0] lim;

    assign rem_r_init = {{(RW-PW){1'b0}}, s2_mag_r_reg} << FRAC_BITS;
    assign rem_i_init = {{(RW-PW){1'b0}}, s2_mag_i_reg} << FRAC_BITS;
    assign lim        = {{(RW-PW){1'b0}}, s2_den_reg} << (W + 1);

    logic              c_valid  [NSTEP+1];
    logic [RW-1:0]     c_rem_r  [NSTEP+1];
    logic [RW-1:0]     c_rem_i  [NSTEP+1];
    logic [W:0]        c_q_r    [NSTEP+1];
    logic [W:0]        c_q_i    [NSTEP+1];
    logic [PW-1:0]     c_den    [NSTEP+1];
    logic [SQW-1:0]    c_sq_rem [NSTEP+1];
    logic [W-1:0]      c_root   [NSTEP+1];
    logic [SIDE_W-1:0] c_side   [NSTEP+1];

    logic              s3_valid_reg;
    logic [RW-1:0]     s3_rem_r_reg;
    logic [RW-1:0]     s3_rem_i_reg;
    logic [PW-1:0]     s3_den_reg;
    logic [SQW-1:0]    s3_sq_rem_reg;
    logic [SIDE_W-1:0] s3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_rem_r_reg  <= rem_r_init;
            s3_rem_i_reg  <= rem_i_init;
            s3_den_reg    <= s2_den_reg;
            s3_sq_rem_reg <= {1'b0, s2_n_reg};
            s3_side_reg   <= {s2_sel_reg, s2_early_re_reg, s2_early_im_reg, s2_early_st_reg,
                              s2_neg_r_reg, s2_neg_i_reg,
                              rem_r_init >= lim, rem_i_init >= lim};
        end
    end

    assign c_valid[0]  = s3_valid_reg;
    assign c_rem_r[0]  = s3_rem_r_reg;
    assign c_rem_i[0]  = s3_rem_i_reg;
    assign c_q_r[0]    = '0;
    assign c_q_i[0]    = '0;
    assign c_den[0]    = s3_den_reg;
    assign c_sq_rem[0] = s3_sq_rem_reg;
    assign c_root[0]   = '0;
    assign c_side[0]   = s3_side_reg;

    generate
        for (genvar k = 0; k < NSTEP; k++)
        begin : g_step
            cau_step #(
                .DATA_WIDTH (DATA_WIDTH),
                .FRAC_BITS  (FRAC_BITS),
                .IDX        (k),
                .SIDE_W     (SIDE_W)
            ) u_step (
                .clk        (clk),
                .rst_n      (rst_n),
                .en         (en),
                .in_valid   (c_valid[k]),
                .in_rem_r   (c_rem_r[k]),
                .in_rem_i   (c_rem_i[k]),
                .in_q_r     (c_q_r[k]),
                .in_q_i     (c_q_i[k]),
                .in_den     (c_den[k]),
                .in_sq_rem  (c_sq_rem[k]),
                .in_root    (c_root[k]),
                .in_side    (c_side[k]),
                .out_valid  (c_valid[k+1]),
                .out_rem_r  (c_rem_r[k+1]),
                .out_rem_i  (c_rem_i[k+1]),
                .out_q_r    (c_q_r[k+1]),
                .out_q_i    (c_q_i[k+1]),
                .out_den    (c_den[k+1]),
                .out_sq_rem (c_sq_rem[k+1]),
                .out_root   (c_root[k+1]),
                .out_side   (c_side[k+1])
            );
        end
    endgenerate

    // final stage: sign, saturate, select
    logic [1:0]       f_sel_bits;
    logic [1:0]       f_st_bits;
    sel_t             f_sel;
    logic [W-1:0]     f_early_re;
    logic [W-1:0]     f_early_im;
    cau_pkg::status_t f_early_st;
    logic             f_neg_r;
    logic             f_neg_i;
    logic             f_ovf_r;
    logic             f_ovf_i;
    logic [W:0]       q_r;
    logic [W:0]       q_i;
    logic             dsat_r;
    logic             dsat_i;
    logic [W-1:0]     dval_r;
    logic [W-1:0]     dval_i;
    logic [W-1:0]     out_re_next;
    logic [W-1:0]     out_im_next;
    cau_pkg::status_t out_st_next;

    assign {f_sel_bits, f_early_re, f_early_im, f_st_bits, f_neg_r, f_neg_i, f_ovf_r, f_ovf_i}
        = c_side[NSTEP];
    assign f_sel      = sel_t'(f_sel_bits);
    assign f_early_st = cau_pkg::status_t'(f_st_bits);
    assign q_r = f_ovf_r ? '1 : c_q_r[NSTEP];
    assign q_i = f_ovf_i ? '1 : c_q_i[NSTEP];

    always_comb
    begin
        if (f_neg_r)
        begin
            dsat_r = q_r[W] || (q_r[W-1] && (|q_r[W-2:0]));
            dval_r = dsat_r ? MINNEG : -q_r[W-1:0];
        end
        else
        begin
            dsat_r = q_r[W] || q_r[W-1];
            dval_r = dsat_r ? MAXPOS : q_r[W-1:0];
        end
        if (f_neg_i)
        begin
            dsat_i = q_i[W] || (q_i[W-1] && (|q_i[W-2:0]));
            dval_i = dsat_i ? MINNEG : -q_i[W-1:0];
        end
        else
        begin
            dsat_i = q_i[W] || q_i[W-1];
            dval_i = dsat_i ? MAXPOS : q_i[W-1:0];
        end
    end

    always_comb
    begin
        unique case (f_sel)
            SEL_DIV:
            begin
                out_re_next = dval_r;
                out_im_next = dval_i;
                out_st_next = (dsat_r || dsat_i) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end
            SEL_MAG:
            begin
                out_re_next = c_root[NSTEP][W-1] ? MAXPOS : c_root[NSTEP];
                out_im_next = '0;
                out_st_next = c_root[NSTEP][W-1] ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end
            default:
            begin
                out_re_next = f_early_re;
                out_im_next = f_early_im;
                out_st_next = f_early_st;
            end
        endcase
    end

    logic [W-1:0]     res_re_reg;
    logic [W-1:0]     res_im_reg;
    cau_pkg::status_t res_st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            res_valid_reg <= c_valid[NSTEP];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_re_reg <= out_re_next;
            res_im_reg <= out_im_next;
            res_st_reg <= out_st_next;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.result_real = res_re_reg;
    assign res.result_imag = res_im_reg;
    assign res.status      = res_st_reg;

endmodule

/* src/cau_step.sv */
// One pipeline stage of the shared divide / square root chain: settles one
// quotient bit per divider lane, one root bit if IDX < W. Depends on nothing.
module cau_step #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 8,
    parameter int IDX        = 0,
    parameter int SIDE_W     = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [3*DATA_WIDTH+FRAC_BITS:0] in_rem_r,
    input  logic [3*DATA_WIDTH+FRAC_BITS:0] in_rem_i,
    input  logic [DATA_WIDTH:0]       in_q_r,
    input  logic [DATA_WIDTH:0]       in_q_i,
    input  logic [2*DATA_WIDTH-1:0]   in_den,
    input  logic [2*DATA_WIDTH:0]     in_sq_rem,
    input  logic [DATA_WIDTH-1:0]     in_root,
    input  logic [SIDE_W-1:0]         in_side,
    output logic                      out_valid,
    output logic [3*DATA_WIDTH+FRAC_BITS:0] out_rem_r,
    output logic [3*DATA_WIDTH+FRAC_BITS:0] out_rem_i,
    output logic [DATA_WIDTH:0]       out_q_r,
    output logic [DATA_WIDTH:0]       out_q_i,
    output logic [2*DATA_WIDTH-1:0]   out_den,
    output logic [2*DATA_WIDTH:0]     out_sq_rem,
    output logic [DATA_WIDTH-1:0]     out_root,
    output logic [SIDE_W-1:0]         out_side
);
    localparam int W   = DATA_WIDTH;
    localparam int PW  = 2 * W;
    localparam int RW  = 3 * W + FRAC_BITS + 1;
    localparam int SQW = 2 * W + 1;
    localparam int DB  = W - IDX;

    logic [RW-1:0]  dsh;
    logic           take_r;
    logic           take_i;
    logic [RW-1:0]  rem_r_next;
    logic [RW-1:0]  rem_i_next;
    logic [W:0]     q_r_next;
    logic [W:0]     q_i_next;
    logic [SQW-1:0] sq_rem_next;
    logic [W-1:0]   root_next;
    logic           valid_reg;
    logic [RW-1:0]  rem_r_reg;
    logic [RW-1:0]  rem_i_reg;
    logic [W:0]     q_r_reg;
    logic [W:0]     q_i_reg;
    logic [PW-1:0]  den_reg;
    logic [SQW-1:0] sq_rem_reg;
    logic [W-1:0]   root_reg;
    logic [SIDE_W-1:0] side_reg;

    assign dsh    = {{(RW-PW){1'b0}}, in_den} << DB;
    assign take_r = in_rem_r >= dsh;
    assign take_i = in_rem_i >= dsh;

    always_comb
    begin
        rem_r_next   = take_r ? in_rem_r - dsh : in_rem_r;
        rem_i_next   = take_i ? in_rem_i - dsh : in_rem_i;
        q_r_next     = in_q_r;
        q_i_next     = in_q_i;
        q_r_next[DB] = take_r;
        q_i_next[DB] = take_i;
    end

    generate
        if (IDX < W)
        begin : g_root
            localparam int SB = W - 1 - IDX;
            logic [SQW-1:0] trial;
            logic           take_s;

            assign trial  = ({{(SQW-W){1'b0}}, in_root} << (SB + 1))
                            | ({{(SQW-1){1'b0}}, 1'b1} << (2 * SB));
            assign take_s = in_sq_rem >= trial;

            always_comb
            begin
                sq_rem_next   = take_s ? in_sq_rem - trial : in_sq_rem;
                root_next     = in_root;
                root_next[SB] = take_s;
            end
        end
        else
        begin : g_no_root
            assign sq_rem_next = in_sq_rem;
            assign root_next   = in_root;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_r_reg  <= rem_r_next;
            rem_i_reg  <= rem_i_next;
            q_r_reg    <= q_r_next;
            q_i_reg    <= q_i_next;
            den_reg    <= in_den;
            sq_rem_reg <= sq_rem_next;
            root_reg   <= root_next;
            side_reg   <= in_side;
        end
    end

    assign out_valid  = valid_reg;
    assign out_rem_r  = rem_r_reg;
    assign out_rem_i  = rem_i_reg;
    assign out_q_r    = q_r_reg;
    assign out_q_i    = q_i_reg;
    assign out_den    = den_reg;
    assign out_sq_rem = sq_rem_reg;
    assign out_root   = root_reg;
    assign out_side   = side_reg;

endmodule

/* src/cau_checker.sv */
// Port-level checks of the complex arithmetic unit, bound to its top level.
// Depends on cau_pkg and complex_arithmetic_unit.
module cau_checker #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cmd_valid,
    input logic                  cmd_ready,
    input logic                  res_valid,
    input logic                  res_ready,
    input logic [DATA_WIDTH-1:0] res_real,
    input logic [DATA_WIDTH-1:0] res_imag,
    input logic [1:0]            res_status
);
    localparam logic [DATA_WIDTH-1:0] MAXPOS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] MINNEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // the pipe holds only behind an untaken result
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> (res_valid && !res_ready))
        else $error("input stalled without an output stall");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(res_real)
                                       && $stable(res_imag) && $stable(res_status)))
        else $error("result beat changed under stall");

    a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_status == cau_pkg::ST_DIVZ) |-> (res_real == '0 && res_imag == '0))
        else $error("divide by zero with nonzero result");

    a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_status == cau_pkg::ST_SAT)
        |-> (res_real == MAXPOS || res_real == MINNEG
             || res_imag == MAXPOS || res_imag == MINNEG))
        else $error("saturated status with no part at a bound");

endmodule

bind complex_arithmetic_unit cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_real   (res.result_real),
    .res_imag   (res.result_imag),
    .res_status (res.status)
);
